### src/dro_pkg.sv
package dro_pkg;

  // field widths of the item and result payloads
  localparam int DENS_W   = 7;
  localparam int CENTER_W = 11;
  localparam int SPAN_W   = 11;

  // configuration register widths
  localparam int THR_W      = 7;
  localparam int GAP_W      = 8;
  localparam int START_W    = 11;
  localparam int SLOPE_W    = 16;
  localparam int OFFS_W     = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // configuration reset values
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = 7'd30;
  localparam logic [GAP_W-1:0]   GAP_LIMIT_RST   = 8'd20;
  localparam logic [START_W-1:0] START_ROW_RST   = 11'd540;
  localparam logic [SLOPE_W-1:0] SIZE_SLOPE_RST  = 16'd1885;
  localparam logic [OFFS_W-1:0]  SIZE_OFFSET_RST = 11'd137;

  // defaults of the top level parameters
  localparam int MAX_ROWS_DEF    = 2048;
  localparam int QUEUE_DEPTH_DEF = 4;

  // divide by 5 for the window average: exact for sums below 1024
  localparam int              AVG_MULT_W = 8;
  localparam logic [7:0]      AVG_MULT   = 8'd205;
  localparam int              AVG_SHIFT  = 10;

  // divide by 10000: ceil(2^43 / 10000), exact for products below 2^29
  localparam int              RECIP_W     = 30;
  localparam logic [29:0]     RECIP_MULT  = 30'd879609303;
  localparam int              RECIP_SHIFT = 43;

  localparam logic KIND_OBJECT   = 1'b0;
  localparam logic KIND_OVERSIZE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_GAP_LIMIT   = 3'd1,
    REG_START_ROW   = 3'd2,
    REG_SIZE_SLOPE  = 3'd3,
    REG_SIZE_OFFSET = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [GAP_W-1:0]   gap_limit;
    logic [START_W-1:0] start_row;
    logic [SLOPE_W-1:0] size_slope;
    logic [OFFS_W-1:0]  size_offset;
  } cfg_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              first_row;
    logic              last_row;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [CENTER_W-1:0] center_row;
    logic [SPAN_W-1:0]   span;
    logic                last_of_run;
  } out_item_t;

endpackage

### src/dro_fifo.sv
module dro_fifo
  import dro_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/dro_front.sv
module dro_front
  import dro_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int CNT_W = $clog2(MAX_ROWS + 1),
  localparam int ENT_W = 2 * (1 + 2 * CNT_W)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             push,
  output logic [ENT_W-1:0] push_data,
  input  logic             fifo_full
);

  localparam int E_W     = CNT_W;
  localparam int RC_W    = (ROW_W > START_W) ? ROW_W : START_W;
  localparam int SUM_W   = DENS_W + 3;
  localparam int AVG_P_W = SUM_W + AVG_MULT_W;

  typedef struct packed {
    logic              v;
    logic [ROW_W-1:0]  row;
    logic [DENS_W-1:0] val;
  } judge_t;

  typedef struct packed {
    logic             in_run;
    logic [ROW_W-1:0] begin_row;
    logic [ROW_W-1:0] high_row;
    logic [GAP_W-1:0] gap;
  } run_t;

  typedef struct packed {
    logic           v;
    logic [E_W-1:0] e;
    logic [E_W-1:0] s;
  } close_t;

  // filter side
  logic [4:0][DENS_W-1:0] win_r, win_nxt, w, ws;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt, c0, c1;
  logic [SUM_W-1:0]       sum;
  logic [AVG_P_W-1:0]     avg_prod;
  judge_t [2:0]           jd_r, jd_nxt;
  logic                   first_r;
  logic                   last_r;
  logic                   a_v_r;

  // run tracking side
  run_t                   run_r, run_nxt, st;
  close_t [3:0]           cl;
  close_t                 ev0, ev1;
  logic                   b_go;

  function automatic close_t mk_close(input run_t rs);
    close_t ev;
    ev.v = 1'b1;
    ev.e = E_W'(rs.high_row) + E_W'(1);
    ev.s = E_W'(rs.high_row - rs.begin_row) + E_W'(1);
    return ev;
  endfunction

  // window shift and the rows this item makes ready for judging
  always_comb begin
    w        = win_r;
    c0       = cnt_r;
    if (in_data.first_row) begin
      w  = '0;
      c0 = '0;
    end
    ws       = w;
    c1       = c0;
    jd_nxt   = '0;
    sum      = '0;
    avg_prod = '0;
    if (c0 < CNT_W'(MAX_ROWS)) begin
      ws = {w[3:0], in_data.density};
      c1 = c0 + CNT_W'(1);
      if (c0 >= CNT_W'(2)) begin
        sum = SUM_W'(ws[0]) + SUM_W'(ws[1]) + SUM_W'(ws[2]) + SUM_W'(ws[3]) +
              SUM_W'(ws[4]);
        avg_prod      = sum * AVG_MULT;
        jd_nxt[0].v   = 1'b1;
        jd_nxt[0].row = ROW_W'(c0 - CNT_W'(2));
        // the first two rows of a profile pass unsmoothed
        jd_nxt[0].val = (c0 < CNT_W'(4)) ? ws[2] : avg_prod[AVG_SHIFT +: DENS_W];
      end
    end
    if (in_data.last_row) begin
      if (c1 >= CNT_W'(2)) begin
        jd_nxt[1].v   = 1'b1;
        jd_nxt[1].row = ROW_W'(c1 - CNT_W'(2));
        jd_nxt[1].val = ws[1];
      end
      if (c1 >= CNT_W'(1)) begin
        jd_nxt[2].v   = 1'b1;
        jd_nxt[2].row = ROW_W'(c1 - CNT_W'(1));
        jd_nxt[2].val = ws[0];
      end
      win_nxt = '0;
      cnt_nxt = '0;
    end else begin
      win_nxt = ws;
      cnt_nxt = c1;
    end
  end

  // up to three judged rows plus the flush, applied in order
  always_comb begin
    st  = run_r;
    cl  = '0;
    ev0 = '0;
    ev1 = '0;
    if (first_r) begin
      st = '0;
    end
    for (int k = 0; k < 3; k++) begin
      if (jd_r[k].v && (RC_W'(jd_r[k].row) >= RC_W'(cfg.start_row))) begin
        if (jd_r[k].val >= cfg.threshold) begin
          if (!st.in_run) begin
            st.in_run    = 1'b1;
            st.begin_row = jd_r[k].row;
          end
          st.high_row = jd_r[k].row;
          st.gap      = '0;
        end else if (st.in_run) begin
          if (st.gap >= cfg.gap_limit) begin
            cl[k]     = mk_close(st);
            st.in_run = 1'b0;
            st.gap    = '0;
          end else begin
            st.gap = st.gap + GAP_W'(1);
          end
        end
      end
    end
    if (last_r && st.in_run) begin
      cl[3] = mk_close(st);
    end
    if (last_r) begin
      st = '0;
    end
    run_nxt = st;
    // at most two closes can come from one item
    for (int k = 0; k < 4; k++) begin
      if (cl[k].v) begin
        if (!ev0.v) begin
          ev0 = cl[k];
        end else if (!ev1.v) begin
          ev1 = cl[k];
        end
      end
    end
  end

  assign b_go      = a_v_r && (!ev0.v || !fifo_full);
  assign in_ready  = !a_v_r || b_go;
  assign push      = b_go && ev0.v;
  assign push_data = {ev1, ev0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      win_r <= '0;
      cnt_r <= '0;
      run_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        a_v_r <= 1'b1;
        win_r <= win_nxt;
        cnt_r <= cnt_nxt;
      end else if (b_go) begin
        a_v_r <= 1'b0;
      end
      if (b_go) begin
        run_r <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      jd_r    <= jd_nxt;
      first_r <= in_data.first_row;
      last_r  <= in_data.last_row;
    end
  end

endmodule

### src/dro_back.sv
module dro_back
  import dro_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int CNT_W = $clog2(MAX_ROWS + 1),
  localparam int ENT_W = 2 * (1 + 2 * CNT_W)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             fifo_empty,
  output logic             pop,
  input  logic [ENT_W-1:0] pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int E_W   = CNT_W;
  localparam int Q_W   = E_W + SLOPE_W;
  localparam int QUO_W = E_W + 3;
  localparam int P_W   = ((QUO_W > OFFS_W) ? QUO_W : OFFS_W) + 1;
  localparam int CMP_W = ((P_W + 3) > (E_W + 3)) ? (P_W + 3) : (E_W + 3);
  localparam int PR_W  = Q_W + RECIP_W;

  typedef struct packed {
    logic           v;
    logic [E_W-1:0] e;
    logic [E_W-1:0] s;
  } close_t;

  typedef struct packed {
    logic           v;
    logic [E_W-1:0] e;
    logic [E_W-1:0] s;
    logic [E_W-1:0] c;
  } lane_t;

  close_t [1:0]                head;
  lane_t  [1:0]                lane_in, l1_r, l2_r, l3_r;
  logic   [1:0][Q_W-1:0]       q_nxt, q2_r;
  logic   [1:0][PR_W-1:0]      prod;
  logic   [1:0][QUO_W-1:0]     quo_nxt, quo3_r;
  logic                        v1_r, v2_r, v3_r;
  logic                        adv;

  logic   [1:0][P_W-1:0]       p;
  logic   [1:0][CMP_W-1:0]     s_c, p_c, s3, s3p, p3, p4, p5;
  logic   [1:0][E_W+1:0]       sw, s34;
  logic   [1:0]                is_one, is_two, is_big;
  logic   [1:0][1:0]           lane_n;
  out_item_t [1:0][1:0]        item;
  out_item_t [1:0]             res;
  logic   [1:0]                res_cnt;

  out_item_t [1:0]             slot_r;
  logic   [1:0]                rem_r;

  // front of the pipe: center of each closed run
  always_comb begin
    head = pop_data;
    for (int l = 0; l < 2; l++) begin
      lane_in[l].v = head[l].v;
      lane_in[l].e = head[l].e;
      lane_in[l].s = head[l].s;
      lane_in[l].c = head[l].e - (head[l].s >> 1);
    end
  end

  // expected size: center * slope, then / 10000 by reciprocal
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_nxt[l]   = l1_r[l].c * cfg.size_slope;
      prod[l]    = q2_r[l] * RECIP_MULT;
      quo_nxt[l] = prod[l][RECIP_SHIFT +: QUO_W];
    end
  end

  // size classes compared with the thirds of p multiplied out
  always_comb begin
    res     = '0;
    res_cnt = '0;
    for (int l = 0; l < 2; l++) begin
      p[l]      = P_W'(quo3_r[l]) + P_W'(cfg.size_offset);
      s_c[l]    = CMP_W'(l3_r[l].s);
      p_c[l]    = CMP_W'(p[l]);
      s3[l]     = CMP_W'(3) * s_c[l];
      s3p[l]    = s3[l] + CMP_W'(3);
      p3[l]     = CMP_W'(3) * p_c[l];
      p4[l]     = p_c[l] << 2;
      p5[l]     = p4[l] + p_c[l];
      is_one[l] = (p_c[l] < s3[l]) && (s3p[l] <= p5[l]);
      is_two[l] = !is_one[l] && (s3p[l] > p4[l]) && (s_c[l] < p3[l]);
      is_big[l] = !is_one[l] && !is_two[l] && (s_c[l] >= p3[l]);
      sw[l]     = (E_W + 2)'(l3_r[l].s);
      s34[l]    = (sw[l] + (sw[l] << 1)) >> 2;

      item[l] = '0;
      if (is_two[l]) begin
        item[l][0].kind       = KIND_OBJECT;
        item[l][0].center_row = CENTER_W'(l3_r[l].e - E_W'(s34[l]));
        item[l][0].span       = SPAN_W'(l3_r[l].s >> 1);
        item[l][1].kind       = KIND_OBJECT;
        item[l][1].center_row = CENTER_W'(l3_r[l].e - (l3_r[l].s >> 2));
        item[l][1].span       = SPAN_W'(l3_r[l].s >> 1);
      end else begin
        item[l][0].kind       = is_big[l] ? KIND_OVERSIZE : KIND_OBJECT;
        item[l][0].center_row = CENTER_W'(l3_r[l].c);
        item[l][0].span       = SPAN_W'(l3_r[l].s);
      end

      if (!l3_r[l].v) begin
        lane_n[l] = 2'd0;
      end else if (is_two[l]) begin
        lane_n[l] = 2'd2;
      end else if (is_one[l] || is_big[l]) begin
        lane_n[l] = 2'd1;
      end else begin
        lane_n[l] = 2'd0;
      end
    end

    // keep the first two results of the item
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < 2; j++) begin
        if ((2'(j) < lane_n[l]) && !res_cnt[1]) begin
          res[res_cnt[0]] = item[l][j];
          res_cnt         = res_cnt + 2'd1;
        end
      end
    end
    if (res_cnt == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (res_cnt == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end
  end

  assign adv       = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_ready);
  assign pop       = adv && !fifo_empty;
  assign out_valid = (rem_r != 2'd0);
  assign out_data  = slot_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      rem_r <= 2'd0;
    end else if (adv) begin
      v1_r  <= !fifo_empty;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      rem_r <= v3_r ? res_cnt : 2'd0;
    end else if ((rem_r == 2'd2) && out_ready) begin
      rem_r <= 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r   <= lane_in;
      l2_r   <= l1_r;
      q2_r   <= q_nxt;
      l3_r   <= l2_r;
      quo3_r <= quo_nxt;
      if (v3_r) begin
        slot_r <= res;
      end
    end else if ((rem_r == 2'd2) && out_ready) begin
      slot_r[0] <= slot_r[1];
    end
  end

endmodule

### src/density_run_object_detector.sv
// throughput: one input beat per cycle unless a closed run waits on a full queue; results
// leave one beat per cycle while out_ready is high, from a two-slot output register, so an
// item that closes into two objects holds the back pipe until its first beat is taken
// a 4-entry queue of closed runs sits between run tracking and the size check pipe
// reset: synchronous, active low; clears the filter, run state and queues and loads the
// default register values; no clearing pass, items are taken in the first cycle after reset
module density_run_object_detector
  import dro_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int ENT_W = 2 * (1 + 2 * CNT_W);

  cfg_t             cfg_r;
  logic             q_push;
  logic [ENT_W-1:0] q_push_data;
  logic             q_full;
  logic             q_pop;
  logic [ENT_W-1:0] q_pop_data;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold   <= THRESHOLD_RST;
      cfg_r.gap_limit   <= GAP_LIMIT_RST;
      cfg_r.start_row   <= START_ROW_RST;
      cfg_r.size_slope  <= SIZE_SLOPE_RST;
      cfg_r.size_offset <= SIZE_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:   cfg_r.threshold   <= cfg_wdata[THR_W-1:0];
        REG_GAP_LIMIT:   cfg_r.gap_limit   <= cfg_wdata[GAP_W-1:0];
        REG_START_ROW:   cfg_r.start_row   <= cfg_wdata[START_W-1:0];
        REG_SIZE_SLOPE:  cfg_r.size_slope  <= cfg_wdata[SLOPE_W-1:0];
        REG_SIZE_OFFSET: cfg_r.size_offset <= cfg_wdata[OFFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dro_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (q_push_data),
    .fifo_full (q_full)
  );

  dro_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  dro_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (q_empty),
    .pop        (q_pop),
    .pop_data   (q_pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
